FILE: rtl/srse_pkg.sv
// Shared types, opcodes, status codes and controller commands for the edge store.
`timescale 1ns / 1ps
package srse_pkg;

    localparam int DEF_MAX_NODES = 1024;
    localparam int DEF_MAX_EDGES = 4096;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_APPEND = 2'd2;
    localparam logic [1:0] OP_COUNT  = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_MISS    = 3'd1;
    localparam logic [2:0] ST_NEW     = 3'd2;
    localparam logic [2:0] ST_BADNODE = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    localparam logic [4:0] C_NONE      = 5'd0;
    localparam logic [4:0] C_LOAD      = 5'd1;
    localparam logic [4:0] C_APPEND    = 5'd2;
    localparam logic [4:0] C_RES_PLAIN = 5'd3;
    localparam logic [4:0] C_RES_CNT   = 5'd4;
    localparam logic [4:0] C_RES_HIT   = 5'd5;
    localparam logic [4:0] C_RES_NEW   = 5'd6;
    localparam logic [4:0] C_RD_START  = 5'd7;
    localparam logic [4:0] C_GOT_START = 5'd8;
    localparam logic [4:0] C_GOT_END   = 5'd9;
    localparam logic [4:0] C_PROBE     = 5'd10;
    localparam logic [4:0] C_STEP      = 5'd11;
    localparam logic [4:0] C_FINAL     = 5'd12;
    localparam logic [4:0] C_HIT       = 5'd13;
    localparam logic [4:0] C_SH_INIT   = 5'd14;
    localparam logic [4:0] C_SH_RD     = 5'd15;
    localparam logic [4:0] C_SH_WR     = 5'd16;
    localparam logic [4:0] C_SH_PUT    = 5'd17;
    localparam logic [4:0] C_RS_RD     = 5'd18;
    localparam logic [4:0] C_RS_WR     = 5'd19;
    localparam logic [4:0] C_OUT       = 5'd20;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [9:0]  source_node;
        logic [9:0]  target_node;
        logic [31:0] edge_weight;
    } srse_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] result_weight;
        logic [11:0] edge_position;
        logic [12:0] neighbor_count;
    } srse_out_t;

    typedef struct packed {
        logic [4:0] code;
        logic [2:0] status;
    } srse_cmd_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       bad_node;
        logic       last_row;
        logic       nodes_full;
        logic       edges_full;
        logic       search_more;
        logic       hit;
        logic       shift_more;
        logic       rows_more;
        logic       out_free;
    } srse_sts_t;

endpackage

FILE: rtl/srse_chan_if.sv
// Valid/ready channel carrying one payload struct.
`timescale 1ns / 1ps
interface srse_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/srse_datapath.sv
// Datapath: row-start, column and weight memories, counters, search and result registers.
`timescale 1ns / 1ps
module srse_datapath
    import srse_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int MAX_EDGES = DEF_MAX_EDGES
) (
    input  logic      clk,
    input  logic      rst_n,
    input  srse_in_t  req_data,
    input  srse_cmd_t cmd,
    output srse_sts_t sts,
    input  logic      rsp_ready,
    output logic      rsp_valid,
    output srse_out_t rsp_data
);

    localparam int NW  = $clog2(MAX_NODES + 1);
    localparam int NAW = $clog2(MAX_NODES);
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam int EAW = $clog2(MAX_EDGES);
    localparam int CW  = (NW > 11) ? NW : 11;

    logic [EW-1:0] row_mem [MAX_NODES];
    logic [9:0]    col_mem [MAX_EDGES];
    logic [31:0]   wgt_mem [MAX_EDGES];

    logic [EW-1:0]  row_rd;
    logic [9:0]     col_rd;
    logic [31:0]    wgt_rd;
    logic           row_we;
    logic [NAW-1:0] row_wa;
    logic [NAW-1:0] row_ra;
    logic [EW-1:0]  row_wd;
    logic           col_we;
    logic           wgt_we;
    logic [EAW-1:0] e_wa;
    logic [EAW-1:0] e_ra;
    logic [9:0]     col_wd;
    logic [31:0]    wgt_wd;

    logic [1:0]    op_reg;
    logic [9:0]    src_reg;
    logic [9:0]    tgt_reg;
    logic [31:0]   wgt_reg;
    logic [EW-1:0] start_reg;
    logic [EW-1:0] end_reg;
    logic [EW-1:0] lo_reg;
    logic [EW-1:0] hi_reg;
    logic [EW-1:0] mid_reg;
    logic [EW-1:0] pos_reg;
    logic [EW-1:0] idx_reg;
    logic [NW-1:0] ridx_reg;
    logic          hit_reg;
    logic [31:0]   wread_reg;
    logic [NW-1:0] node_count_reg;
    logic [EW-1:0] edge_count_reg;
    logic          out_valid_reg;
    srse_out_t     out_data_reg;
    srse_out_t     res_reg;

    logic [EW-1:0] mid_w;
    logic [EW-1:0] cnt_w;
    logic [CW-1:0] src_ext;

    assign mid_w   = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign cnt_w   = end_reg - start_reg;
    assign src_ext = CW'(src_reg);

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_wa] <= row_wd;
        end
        row_rd <= row_mem[row_ra];
    end

    always_ff @(posedge clk)
    begin
        if (col_we)
        begin
            col_mem[e_wa] <= col_wd;
        end
        col_rd <= col_mem[e_ra];
    end

    always_ff @(posedge clk)
    begin
        if (wgt_we)
        begin
            wgt_mem[e_wa] <= wgt_wd;
        end
        wgt_rd <= wgt_mem[e_ra];
    end

    always_comb
    begin
        row_we = 1'b0;
        row_wa = NAW'(ridx_reg);
        row_ra = NAW'(src_reg);
        row_wd = row_rd + EW'(1);
        col_we = 1'b0;
        wgt_we = 1'b0;
        e_wa   = EAW'(idx_reg);
        e_ra   = EAW'(lo_reg);
        col_wd = col_rd;
        wgt_wd = wgt_rd;
        case (cmd.code)
            C_APPEND:
            begin
                row_we = 1'b1;
                row_wa = NAW'(node_count_reg);
                row_wd = edge_count_reg;
            end
            C_GOT_START: row_ra = NAW'(src_ext + CW'(1));
            C_RS_RD:     row_ra = NAW'(ridx_reg);
            C_RS_WR:     row_we = 1'b1;
            C_PROBE:     e_ra = EAW'(mid_w);
            C_SH_RD:     e_ra = EAW'(idx_reg - EW'(1));
            C_SH_WR:
            begin
                col_we = 1'b1;
                wgt_we = 1'b1;
            end
            C_SH_PUT:
            begin
                col_we = 1'b1;
                wgt_we = 1'b1;
                e_wa   = EAW'(pos_reg);
                col_wd = tgt_reg;
                wgt_wd = wgt_reg;
            end
            C_RES_HIT:
            begin
                // overwrite of an existing edge touches only its weight
                wgt_we = (op_reg == OP_INSERT);
                e_wa   = EAW'(pos_reg);
                wgt_wd = wgt_reg;
            end
            default: ;
        endcase
    end

    // payload, search, shift and result registers
    always_ff @(posedge clk)
    begin
        case (cmd.code)
            C_LOAD:
            begin
                op_reg  <= req_data.opcode;
                src_reg <= req_data.source_node;
                tgt_reg <= req_data.target_node;
                wgt_reg <= req_data.edge_weight;
            end
            C_APPEND:
            begin
                res_reg <= '{ST_OK, 32'd0, 12'd0, 13'd0};
            end
            C_RES_PLAIN:
            begin
                res_reg <= '{cmd.status, 32'd0, 12'd0, 13'd0};
            end
            C_RES_CNT:
            begin
                res_reg <= '{cmd.status, 32'd0, 12'd0, 13'(cnt_w)};
            end
            C_RES_HIT:
            begin
                res_reg <= '{cmd.status, (op_reg == OP_INSERT) ? wgt_reg : wread_reg,
                             12'(pos_reg), 13'(cnt_w)};
            end
            C_RES_NEW:
            begin
                res_reg <= '{ST_NEW, 32'd0, 12'(pos_reg), 13'(cnt_w + EW'(1))};
            end
            C_GOT_START:
            begin
                start_reg <= row_rd;
                lo_reg    <= row_rd;
                end_reg   <= edge_count_reg;
                hi_reg    <= edge_count_reg;
            end
            C_GOT_END:
            begin
                end_reg <= row_rd;
                hi_reg  <= row_rd;
            end
            C_PROBE: mid_reg <= mid_w;
            C_STEP:
            begin
                if (col_rd < tgt_reg)
                begin
                    lo_reg <= mid_reg + EW'(1);
                end
                else
                begin
                    hi_reg <= mid_reg;
                end
            end
            C_FINAL: pos_reg <= lo_reg;
            C_HIT:
            begin
                hit_reg   <= (pos_reg < end_reg) && (col_rd == tgt_reg);
                wread_reg <= wgt_rd;
            end
            C_SH_INIT: idx_reg <= edge_count_reg;
            C_SH_WR:   idx_reg <= idx_reg - EW'(1);
            C_SH_PUT:  ridx_reg <= NW'(src_ext + CW'(1));
            C_RS_WR:   ridx_reg <= ridx_reg + NW'(1);
            C_OUT:     out_data_reg <= res_reg;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= '0;
            edge_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.code == C_APPEND)
            begin
                node_count_reg <= node_count_reg + NW'(1);
            end
            if (cmd.code == C_SH_PUT)
            begin
                edge_count_reg <= edge_count_reg + EW'(1);
            end
            if (cmd.code == C_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

    always_comb
    begin
        sts.opcode      = op_reg;
        sts.bad_node    = src_ext >= CW'(node_count_reg);
        sts.last_row    = (src_ext + CW'(1)) >= CW'(node_count_reg);
        sts.nodes_full  = node_count_reg >= NW'(MAX_NODES);
        sts.edges_full  = edge_count_reg >= EW'(MAX_EDGES);
        sts.search_more = lo_reg < hi_reg;
        sts.hit         = hit_reg;
        sts.shift_more  = idx_reg > pos_reg;
        sts.rows_more   = ridx_reg < node_count_reg;
        sts.out_free    = !out_valid_reg || rsp_ready;
    end

endmodule

FILE: rtl/srse_controller.sv
// Controller: sequences search, shift and row-start update one memory access at a time.
`timescale 1ns / 1ps
module srse_controller
    import srse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  srse_sts_t sts,
    output srse_cmd_t cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_START  = 4'd2;
    localparam logic [3:0] S_END    = 4'd3;
    localparam logic [3:0] S_SEARCH = 4'd4;
    localparam logic [3:0] S_STEP   = 4'd5;
    localparam logic [3:0] S_HITCHK = 4'd6;
    localparam logic [3:0] S_DECIDE = 4'd7;
    localparam logic [3:0] S_SHRD   = 4'd8;
    localparam logic [3:0] S_SHWR   = 4'd9;
    localparam logic [3:0] S_RSRD   = 4'd10;
    localparam logic [3:0] S_RSWR   = 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '{C_NONE, ST_OK};
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd        = '{C_LOAD, ST_OK};
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                state_next = S_OUT;
                if (sts.opcode == OP_APPEND)
                begin
                    cmd = sts.nodes_full ? '{C_RES_PLAIN, ST_FULL} : '{C_APPEND, ST_OK};
                end
                else if (sts.bad_node)
                begin
                    cmd = '{C_RES_PLAIN, ST_BADNODE};
                end
                else
                begin
                    cmd        = '{C_RD_START, ST_OK};
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd        = '{C_GOT_START, ST_OK};
                state_next = sts.last_row ? S_SEARCH : S_END;
            end
            S_END:
            begin
                cmd        = '{C_GOT_END, ST_OK};
                state_next = S_SEARCH;
            end
            S_SEARCH:
            begin
                if (sts.opcode == OP_COUNT)
                begin
                    cmd        = '{C_RES_CNT, ST_OK};
                    state_next = S_OUT;
                end
                else if (sts.search_more)
                begin
                    cmd        = '{C_PROBE, ST_OK};
                    state_next = S_STEP;
                end
                else
                begin
                    cmd        = '{C_FINAL, ST_OK};
                    state_next = S_HITCHK;
                end
            end
            S_STEP:
            begin
                cmd        = '{C_STEP, ST_OK};
                state_next = S_SEARCH;
            end
            S_HITCHK:
            begin
                cmd        = '{C_HIT, ST_OK};
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_OUT;
                if (sts.hit)
                begin
                    cmd = '{C_RES_HIT, ST_OK};
                end
                else if (sts.opcode == OP_LOOKUP)
                begin
                    cmd = '{C_RES_CNT, ST_MISS};
                end
                else if (sts.edges_full)
                begin
                    cmd = '{C_RES_CNT, ST_FULL};
                end
                else
                begin
                    cmd        = '{C_SH_INIT, ST_OK};
                    state_next = S_SHRD;
                end
            end
            S_SHRD:
            begin
                if (sts.shift_more)
                begin
                    cmd        = '{C_SH_RD, ST_OK};
                    state_next = S_SHWR;
                end
                else
                begin
                    cmd        = '{C_SH_PUT, ST_OK};
                    state_next = S_RSRD;
                end
            end
            S_SHWR:
            begin
                cmd        = '{C_SH_WR, ST_OK};
                state_next = S_SHRD;
            end
            S_RSRD:
            begin
                if (sts.rows_more)
                begin
                    cmd        = '{C_RS_RD, ST_OK};
                    state_next = S_RSWR;
                end
                else
                begin
                    cmd        = '{C_RES_NEW, ST_NEW};
                    state_next = S_OUT;
                end
            end
            S_RSWR:
            begin
                cmd        = '{C_RS_WR, ST_OK};
                state_next = S_RSRD;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd        = '{C_OUT, ST_OK};
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/sorted_row_sparse_edge_store.sv
// Top level of the compressed-sparse-row edge store: controller, datapath, checks.
//
//   channel  role  payload
//   req      sink  opcode, source_node, target_node, edge_weight
//   rsp      src   status, result_weight, edge_position, neighbor_count
//
// One item at a time: a request is taken only once the last result is registered.
// Append, bad node: straight to the result. Count reads row start and end. Lookup or
// overwrite then binary-searches the row (about log2 of its length probes). Insert of
// a new edge also shifts each later edge and bumps each later row start. Last row: no
// end read. Each memory has one read and one write port. No clearing pass after reset.
// A held result stalls only the final hand-off; the next item may already be taken.
`timescale 1ns / 1ps
module sorted_row_sparse_edge_store
    import srse_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int MAX_EDGES = DEF_MAX_EDGES
) (
    input  logic clk,
    input  logic rst_n,
    srse_chan_if.sink   req,
    srse_chan_if.source rsp
);

    srse_cmd_t cmd;
    srse_sts_t sts;

    srse_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    srse_datapath #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req.data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .rsp_data  (rsp.data)
    );

    a_load_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.code == C_LOAD) |-> (req.valid && req.ready))
        else $error("load without input transfer");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("second item taken while busy");

    a_out_loads_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.code == C_OUT) |=> rsp.valid)
        else $error("result not presented");

    a_out_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.code == C_OUT) |-> (!rsp.valid || rsp.ready))
        else $error("result overwritten");

endmodule

FILE: dv/sorted_row_sparse_edge_store_test.sv
// Self-checking testbench for the compressed-sparse-row edge store.
`timescale 1ns / 1ps
module sorted_row_sparse_edge_store_test;
    import srse_pkg::*;

    localparam int NODE_CAP    = DEF_MAX_NODES;
    localparam int EDGE_CAP    = DEF_MAX_EDGES;
    localparam int RAND_ITEMS  = 1500;
    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int DRAIN_WAIT  = 300;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        srse_in_t  cmd;
        bit        typed;
        srse_out_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    srse_chan_if #(.T(srse_in_t))  req_if ();
    srse_chan_if #(.T(srse_out_t)) rsp_if ();

    sorted_row_sparse_edge_store u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // shadow copy of the graph
    int row_base [NODE_CAP];
    int col_mem  [EDGE_CAP];
    int wgt_mem  [EDGE_CAP];
    int node_total;
    int edge_total;

    srse_out_t pending_results [$];
    int        mismatches;
    int        results_seen;
    int        items_sent;
    int        cycles;
    int        idle_pct;
    int        stall_pct;
    int        hold_asks;
    int        status_hits [5];

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    function automatic srse_out_t edge_store_step(srse_in_t t);
        srse_out_t r;
        int        src;
        int        tgt;
        int        first;
        int        last;
        int        lo;
        int        hi;
        int        mid;
        bit        hit;
        r   = '0;
        src = t.source_node;
        tgt = t.target_node;
        if (t.opcode == OP_APPEND) begin
            if (node_total >= NODE_CAP) begin
                r.status = ST_FULL;
                return r;
            end
            row_base[node_total] = edge_total;
            node_total++;
            r.status = ST_OK;
            return r;
        end
        if (src >= node_total) begin
            r.status = ST_BADNODE;
            return r;
        end
        first = row_base[src];
        last  = (src + 1 >= node_total) ? edge_total : row_base[src + 1];
        r.neighbor_count = 13'(last - first);
        if (t.opcode == OP_COUNT) begin
            r.status = ST_OK;
            return r;
        end
        lo = first;
        hi = last;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (col_mem[mid] < tgt)
                lo = mid + 1;
            else
                hi = mid;
        end
        hit = (lo < last) && (col_mem[lo] == tgt);
        if (t.opcode == OP_LOOKUP) begin
            if (hit) begin
                r.status        = ST_OK;
                r.result_weight = 32'(wgt_mem[lo]);
                r.edge_position = 12'(lo);
            end else begin
                r.status = ST_MISS;
            end
            return r;
        end
        if (hit) begin
            wgt_mem[lo]     = int'(t.edge_weight);
            r.status        = ST_OK;
            r.result_weight = t.edge_weight;
            r.edge_position = 12'(lo);
            return r;
        end
        if (edge_total >= EDGE_CAP) begin
            r.status = ST_FULL;
            return r;
        end
        for (int i = edge_total; i > lo; i--) begin
            col_mem[i] = col_mem[i - 1];
            wgt_mem[i] = wgt_mem[i - 1];
        end
        col_mem[lo] = tgt;
        wgt_mem[lo] = int'(t.edge_weight);
        edge_total++;
        for (int i = src + 1; i < node_total; i++)
            row_base[i]++;
        r.status         = ST_NEW;
        r.edge_position  = 12'(lo);
        r.neighbor_count = 13'(last - first + 1);
        return r;
    endfunction

    // offers one item, waits for the transfer, then records the expectation
    task automatic send_item(srse_in_t t, bit typed, srse_out_t want);
        srse_out_t predicted;
        while ($urandom_range(99) < idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= t;
        do
            @(posedge clk);
        while (!req_if.ready);
        predicted = edge_store_step(t);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
        items_sent++;
    endtask

    task automatic send_op(logic [1:0] op, int src, int tgt, logic [31:0] w);
        srse_in_t t;
        t.opcode      = op;
        t.source_node = 10'(src);
        t.target_node = 10'(tgt);
        t.edge_weight = w;
        send_item(t, 1'b0, '0);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        srse_out_t got;
        srse_out_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.data;
            results_seen++;
            if (got.status < 5)
                status_hits[got.status]++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d weight %h pos %0d count %0d",
                             got.status, got.result_weight, got.edge_position,
                             got.neighbor_count);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.result_weight !== want.result_weight
                    || got.edge_position !== want.edge_position
                    || got.neighbor_count !== want.neighbor_count) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d: expected st %0d w %h pos %0d cnt %0d",
                                 results_seen, want.status, want.result_weight,
                                 want.edge_position, want.neighbor_count);
                        $display("result %0d: got      st %0d w %h pos %0d cnt %0d",
                                 results_seen, got.status, got.result_weight,
                                 got.edge_position, got.neighbor_count);
                    end
                end
            end
        end
    end

    initial begin
        dir_row_t    dir [23];
        srse_in_t    t;
        int          pick;
        int          src;
        int          tgt;

        rst_n        = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_asks    = 0;
        mismatches   = 0;
        results_seen = 0;
        items_sent   = 0;
        node_total   = 0;
        edge_total   = 0;
        foreach (status_hits[i])
            status_hits[i] = 0;

        // directed: empty graph, first rows, extremes, overwrite, misses
        dir[0]  = '{'{OP_LOOKUP, 10'd0, 10'd0, 32'd0}, 1, '{ST_BADNODE, 32'd0, 12'd0, 13'd0}};
        dir[1]  = '{'{OP_COUNT, 10'd0, 10'd0, 32'd0}, 1, '{ST_BADNODE, 32'd0, 12'd0, 13'd0}};
        dir[2]  = '{'{OP_INSERT, 10'd0, 10'd5, 32'd7}, 1, '{ST_BADNODE, 32'd0, 12'd0, 13'd0}};
        dir[3]  = '{'{OP_APPEND, 10'd1023, 10'd1023, 32'hFFFF_FFFF}, 1,
                    '{ST_OK, 32'd0, 12'd0, 13'd0}};
        dir[4]  = '{'{OP_COUNT, 10'd0, 10'd0, 32'd0}, 1, '{ST_OK, 32'd0, 12'd0, 13'd0}};
        dir[5]  = '{'{OP_LOOKUP, 10'd0, 10'd5, 32'd0}, 1, '{ST_MISS, 32'd0, 12'd0, 13'd0}};
        dir[6]  = '{'{OP_INSERT, 10'd0, 10'd5, 32'h1234}, 1, '{ST_NEW, 32'd0, 12'd0, 13'd1}};
        dir[7]  = '{'{OP_LOOKUP, 10'd0, 10'd5, 32'd0}, 1, '{ST_OK, 32'h1234, 12'd0, 13'd1}};
        dir[8]  = '{'{OP_INSERT, 10'd0, 10'd5, 32'hFFFF_FFFF}, 1,
                    '{ST_OK, 32'hFFFF_FFFF, 12'd0, 13'd1}};
        dir[9]  = '{'{OP_INSERT, 10'd0, 10'd1023, 32'd0}, 1, '{ST_NEW, 32'd0, 12'd1, 13'd2}};
        dir[10] = '{'{OP_INSERT, 10'd0, 10'd0, 32'hAAAA_5555}, 1,
                    '{ST_NEW, 32'd0, 12'd0, 13'd3}};
        dir[11] = '{'{OP_LOOKUP, 10'd0, 10'd3, 32'd0}, 1, '{ST_MISS, 32'd0, 12'd0, 13'd3}};
        dir[12] = '{'{OP_APPEND, 10'd0, 10'd0, 32'd0}, 1, '{ST_OK, 32'd0, 12'd0, 13'd0}};
        dir[13] = '{'{OP_INSERT, 10'd1, 10'd7, 32'h5555_AAAA}, 1,
                    '{ST_NEW, 32'd0, 12'd3, 13'd1}};
        dir[14] = '{'{OP_COUNT, 10'd1, 10'd0, 32'd0}, 1, '{ST_OK, 32'd0, 12'd0, 13'd1}};
        dir[15] = '{'{OP_LOOKUP, 10'd1023, 10'd7, 32'd0}, 1,
                    '{ST_BADNODE, 32'd0, 12'd0, 13'd0}};
        dir[16] = '{'{OP_COUNT, 10'd2, 10'd0, 32'd0}, 1, '{ST_BADNODE, 32'd0, 12'd0, 13'd0}};
        dir[17] = '{'{OP_APPEND, 10'd0, 10'd0, 32'd0}, 1, '{ST_OK, 32'd0, 12'd0, 13'd0}};
        dir[18] = '{'{OP_LOOKUP, 10'd2, 10'd0, 32'd0}, 1, '{ST_MISS, 32'd0, 12'd0, 13'd0}};
        dir[19] = '{'{OP_INSERT, 10'd1, 10'd2, 32'h0BAD_F00D}, 0, '0};
        dir[20] = '{'{OP_LOOKUP, 10'd1, 10'd7, 32'd0}, 0, '0};
        dir[21] = '{'{OP_INSERT, 10'd0, 10'd512, 32'h8000_0001}, 0, '0};
        dir[22] = '{'{OP_LOOKUP, 10'd0, 10'd1023, 32'd0}, 0, '0};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir[i])
            send_item(dir[i].cmd, dir[i].typed, dir[i].want);

        // random: a few dozen rows, mostly a narrow target range so hits are common
        for (int n = 0; n < RAND_ITEMS; n++) begin
            case (n / (RAND_ITEMS / 4))
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 46; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 46; end
                default: begin idle_pct = 38; stall_pct = 38; end
            endcase
            if (n == 100)
                hold_asks++;
            pick = $urandom_range(99);
            if (pick < ((node_total < 32) ? 12 : 2))
                t.opcode = OP_APPEND;
            else if (pick < 50)
                t.opcode = OP_INSERT;
            else if (pick < 85)
                t.opcode = OP_LOOKUP;
            else
                t.opcode = OP_COUNT;
            src = ($urandom_range(9) == 0) ? $urandom_range(1023)
                                           : $urandom_range(node_total > 0 ? node_total - 1 : 0);
            tgt = ($urandom_range(7) == 0) ? $urandom_range(1023) : $urandom_range(15);
            t.source_node = 10'(src);
            t.target_node = 10'(tgt);
            t.edge_weight = $urandom;
            send_item(t, 1'b0, '0);
        end

        // closing reads of the first row
        send_op(OP_COUNT, 0, 0, 32'd0);
        send_op(OP_LOOKUP, 0, 1023, 32'd0);
        req_if.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("%0d items, %0d results: ok %0d miss %0d new %0d bad node %0d full %0d",
                 items_sent, results_seen, status_hits[0], status_hits[1], status_hits[2],
                 status_hits[3], status_hits[4]);
        $display("graph ended with %0d nodes and %0d edges, %0d mismatches",
                 node_total, edge_total, mismatches);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
